@@ rtl/core/nearest_palette_color_matcher_macros.svh @@
// assertion macros for the nearest palette colour matcher
// used by the top level only; expects clk and rst_n in scope
`ifndef NEAREST_PALETTE_COLOR_MATCHER_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MATCHER_MACROS_SVH

// same-cycle implication
`define NPCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NPCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/npcm_pkg.sv @@
// shared types and constants for the nearest palette colour matcher
// no dependencies
`timescale 1ns / 1ps

package npcm_pkg;

  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 8;
  localparam int INDEX_W = 8;
  localparam int SIZE_W  = 9;
  localparam int SQ_W    = 16;
  localparam int DIST_W  = 20;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_EXACT = 2'd1;
  localparam logic [1:0] OP_PIXEL = 2'd2;

  localparam logic [CHAN_W-1:0] QUANT_MASK = 8'hF8;
  localparam logic [CHAN_W-1:0] QUANT_FILL = 8'h07;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // travels alongside each palette entry through the distance pipeline
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [INDEX_W-1:0] idx;
  } tag_t;

  function automatic logic [CHAN_W-1:0] quantize(input logic [CHAN_W-1:0] c);
    quantize = (c & QUANT_MASK) | QUANT_FILL;
  endfunction

endpackage

@@ rtl/core/npcm_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module npcm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/npcm_dist.sv @@
// pipelined weighted squared distance unit, one palette entry per cycle
// depends on npcm_pkg; tag enters with the ram read request
`timescale 1ns / 1ps

module npcm_dist (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [npcm_pkg::COLOR_W-1:0] query,
  input  logic [npcm_pkg::COLOR_W-1:0] entry,
  input  npcm_pkg::tag_t               tag_in,
  output logic [npcm_pkg::DIST_W-1:0]  entry_dist,
  output npcm_pkg::tag_t               tag_out
);

  import npcm_pkg::*;

  tag_t              tag1_r, tag2_r, tag3_r, tag4_r;
  logic [CHAN_W-1:0] dr_r, dg_r, db_r;
  logic [CHAN_W-1:0] dr_nxt, dg_nxt, db_nxt;
  logic [SQ_W-1:0]   sr_r, sg_r, sb_r;
  logic [DIST_W-1:0] sum_r, sum_nxt;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    dr_nxt = abs_diff(query[23:16], entry[23:16]);
    dg_nxt = abs_diff(query[15:8],  entry[15:8]);
    db_nxt = abs_diff(query[7:0],   entry[7:0]);
    // 3r + 4g + 2b done with shifts
    sum_nxt = DIST_W'({sr_r, 1'b0}) + DIST_W'(sr_r)
            + DIST_W'({sg_r, 2'b00})
            + DIST_W'({sb_r, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
    end
  end

  always_ff @(posedge clk) begin
    dr_r  <= dr_nxt;
    dg_r  <= dg_nxt;
    db_r  <= db_nxt;
    sr_r  <= SQ_W'(dr_r) * SQ_W'(dr_r);
    sg_r  <= SQ_W'(dg_r) * SQ_W'(dg_r);
    sb_r  <= SQ_W'(db_r) * SQ_W'(db_r);
    sum_r <= sum_nxt;
  end

  assign entry_dist = sum_r;
  assign tag_out    = tag4_r;

endmodule

@@ rtl/core/npcm_seq.sv @@
// scan sequencer: walks the palette, keeps the running minimum, holds the result
// depends on npcm_pkg; drives the ram read port and npcm_dist tags
`timescale 1ns / 1ps

module npcm_seq #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [npcm_pkg::SIZE_W-1:0]          size,
  output logic                                 idle,
  output logic                                 rd_en,
  output logic [$clog2(PALETTE_ENTRIES)-1:0]   rd_addr,
  output npcm_pkg::tag_t                       tag_issue,
  input  logic [npcm_pkg::DIST_W-1:0]          entry_dist,
  input  npcm_pkg::tag_t                       tag_done,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [npcm_pkg::INDEX_W-1:0]         out_index
);

  import npcm_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(PALETTE_ENTRIES);

  state_t             state_r, state_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]  n_r, n_nxt;
  logic [INDEX_W-1:0] best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0]  best_d_r, best_d_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0] out_idx_r, out_idx_nxt;
  logic [SIZE_W-1:0]  n_eff;
  logic               at_last;
  logic               out_free;

  assign n_eff    = (size > MAX_SIZE) ? MAX_SIZE : size;
  assign at_last  = (SIZE_W'(cnt_r) == n_r - SIZE_W'(1));
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (n_eff == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (at_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tag_done.valid && tag_done.last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    idle          = (state_r == ST_IDLE);
    rd_en         = (state_r == ST_SCAN);
    rd_addr       = cnt_r;
    tag_issue     = '{valid: (state_r == ST_SCAN), last: at_last, idx: INDEX_W'(cnt_r)};
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    best_idx_nxt  = best_idx_r;
    best_d_nxt    = best_d_r;
    out_idx_nxt   = out_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cnt_nxt      = '0;
          n_nxt        = n_eff;
          best_idx_nxt = '0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + AW'(1);
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = best_idx_r;
        end
      end
      default: ;
    endcase

    // first entry always taken, later ones only when strictly nearer
    if (tag_done.valid && ((tag_done.idx == '0) || (entry_dist < best_d_r))) begin
      best_idx_nxt = tag_done.idx;
      best_d_nxt   = entry_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    best_idx_r <= best_idx_nxt;
    best_d_r   <= best_d_nxt;
    out_idx_r  <= out_idx_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_index = out_idx_r;

endmodule

@@ rtl/core/nearest_palette_color_matcher.sv @@
// nearest palette colour matcher: top level with palette ram, distance unit, sequencer
// depends on npcm_pkg, npcm_ram, npcm_dist, npcm_seq and the macros header
//
// Input channel (in_valid/in_ready) carries one item: opcode, entry_index, red, green,
// blue. A load item writes one palette entry in the cycle it is accepted and gives no
// result; in_ready stays high, so loads go back to back. A match item (exact colour, or
// pixel with each channel cut to its top 5 bits and filled with ones) searches entries
// 0 .. n-1, n being cfg palette_size clamped to PALETTE_ENTRIES, and returns the index of
// the nearest entry on out_valid/out_ready. Opcode three is taken and dropped.
// During a match the palette ram read port delivers one entry per cycle into a three-stage
// distance pipeline, and the running minimum is updated as each distance leaves it. A
// size of zero gives index 0 without a search. in_ready is low for the whole search, so
// no other item is taken until the search is over. The result sits in an output register;
// if the receiver stalls, loads are still taken, but the next match finishes and waits
// until the register is free. cfg_wr_en writes palette_size at once; it resets to 256.
// Reset (rst_n, synchronous) empties the output register and returns to idle; palette
// entries must be loaded before they are searched.
`timescale 1ns / 1ps
`include "nearest_palette_color_matcher_macros.svh"

module nearest_palette_color_matcher #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [npcm_pkg::SIZE_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_opcode,
  input  logic [npcm_pkg::INDEX_W-1:0] in_entry_index,
  input  logic [npcm_pkg::CHAN_W-1:0]  in_red,
  input  logic [npcm_pkg::CHAN_W-1:0]  in_green,
  input  logic [npcm_pkg::CHAN_W-1:0]  in_blue,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [npcm_pkg::INDEX_W-1:0] out_color_index
);

  import npcm_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic [SIZE_W-1:0]  palette_size_r;
  logic [COLOR_W-1:0] query_r, query_nxt;
  logic               accept;
  logic               start;
  logic               load_we;
  logic               seq_idle;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [COLOR_W-1:0] rd_data;
  logic [DIST_W-1:0]  entry_dist;
  tag_t               tag_issue, tag_done;

  assign accept   = in_valid && in_ready;
  assign start    = accept && ((in_opcode == OP_EXACT) || (in_opcode == OP_PIXEL));
  // loads beyond the palette are dropped
  assign load_we  = accept && (in_opcode == OP_LOAD)
                    && ({1'b0, in_entry_index} < SIZE_W'(PALETTE_ENTRIES));
  assign in_ready = seq_idle;

  always_comb begin
    query_nxt = query_r;
    if (start) begin
      if (in_opcode == OP_PIXEL) begin
        query_nxt = {quantize(in_red), quantize(in_green), quantize(in_blue)};
      end else begin
        query_nxt = {in_red, in_green, in_blue};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_size_r <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      palette_size_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    query_r <= query_nxt;
  end

  npcm_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (in_entry_index[AW-1:0]),
    .wr_data ({in_red, in_green, in_blue}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  npcm_dist u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .query      (query_r),
    .entry      (rd_data),
    .tag_in     (tag_issue),
    .entry_dist (entry_dist),
    .tag_out    (tag_done)
  );

  npcm_seq #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .size       (palette_size_r),
    .idle       (seq_idle),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .tag_issue  (tag_issue),
    .entry_dist (entry_dist),
    .tag_done   (tag_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_index  (out_color_index)
  );

  // a match item takes the block out of idle
  `NPCM_ASSERT_NEXT(a_match_busy, start, !in_ready, "match item did not start a search")
  // a load never produces a result
  `NPCM_ASSERT_NEXT(a_load_silent, load_we && !out_valid, !out_valid, "load item gave a result")
  // the result always names an existing entry
  `NPCM_ASSERT_NOW(a_index_range, out_valid,
                   {1'b0, out_color_index} < SIZE_W'(PALETTE_ENTRIES), "index out of range")
  // distances only come back while a search runs
  `NPCM_ASSERT_NOW(a_tag_busy, tag_done.valid, !seq_idle, "distance arrived while idle")

endmodule

@@ dv/npcm_match_checker.sv @@
// result checker for the nearest palette colour matcher: keeps its own palette and size,
// predicts the colour index of every match item and compares it with the result channel
// depends on npcm_pkg
`timescale 1ns / 1ps

module npcm_match_checker #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [npcm_pkg::SIZE_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [1:0]                   in_opcode,
  input  logic [npcm_pkg::INDEX_W-1:0] in_entry_index,
  input  logic [npcm_pkg::CHAN_W-1:0]  in_red,
  input  logic [npcm_pkg::CHAN_W-1:0]  in_green,
  input  logic [npcm_pkg::CHAN_W-1:0]  in_blue,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [npcm_pkg::INDEX_W-1:0] out_color_index,
  output int                           mismatch_count,
  output int                           pending_count
);
  import npcm_pkg::*;

  logic [COLOR_W-1:0] palette [PALETTE_ENTRIES];
  logic [SIZE_W-1:0]  size_reg = SIZE_RESET;
  logic [INDEX_W-1:0] expected_index_q [$];
  int                 errors = 0;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  function automatic logic [DIST_W-1:0] weighted_distance(
    input logic [CHAN_W-1:0]  r,
    input logic [CHAN_W-1:0]  g,
    input logic [CHAN_W-1:0]  b,
    input logic [COLOR_W-1:0] entry
  );
    int dr, dg, db;
    dr = int'(r) - int'(entry[2*CHAN_W +: CHAN_W]);
    dg = int'(g) - int'(entry[CHAN_W +: CHAN_W]);
    db = int'(b) - int'(entry[0 +: CHAN_W]);
    return DIST_W'(3 * dr * dr + 4 * dg * dg + 2 * db * db);
  endfunction

  // first strictly smaller distance wins, so ties stay with the lowest index
  function automatic logic [INDEX_W-1:0] nearest_index(
    input logic [CHAN_W-1:0] r,
    input logic [CHAN_W-1:0] g,
    input logic [CHAN_W-1:0] b
  );
    int                 n;
    logic [INDEX_W-1:0] best;
    logic [DIST_W-1:0]  best_dist;
    logic [DIST_W-1:0]  entry_dist;
    n         = (size_reg > PALETTE_ENTRIES) ? PALETTE_ENTRIES : int'(size_reg);
    best      = '0;
    best_dist = '1;
    for (int i = 0; i < n; i++) begin
      entry_dist = weighted_distance(r, g, b, palette[i]);
      if (i == 0 || entry_dist < best_dist) begin
        best      = INDEX_W'(i);
        best_dist = entry_dist;
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    logic [INDEX_W-1:0] want;
    if (!rst_n) begin
      size_reg = SIZE_RESET;
      expected_index_q.delete();
      errors = 0;
    end else begin
      // results first, so an item accepted at this edge cannot absorb a stray result
      if (out_valid && out_ready) begin
        if (expected_index_q.size() == 0) begin
          errors++;
          $display("%0t: color_index with no match item waiting, expected none, got %0d",
                   $time, out_color_index);
        end else begin
          want = expected_index_q.pop_front();
          if (out_color_index !== want) begin
            errors++;
            $display("%0t: color_index mismatch, expected %0d, got %0d",
                     $time, want, out_color_index);
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_opcode)
          OP_LOAD: begin
            if (in_entry_index < PALETTE_ENTRIES)
              palette[in_entry_index] = {in_red, in_green, in_blue};
          end
          OP_EXACT: begin
            expected_index_q.push_back(nearest_index(in_red, in_green, in_blue));
          end
          OP_PIXEL: begin
            expected_index_q.push_back(nearest_index((in_red & QUANT_MASK) | QUANT_FILL,
                                                     (in_green & QUANT_MASK) | QUANT_FILL,
                                                     (in_blue & QUANT_MASK) | QUANT_FILL));
          end
          default: ;
        endcase
      end
      if (cfg_wr_en)
        size_reg = cfg_wr_data;
    end
    mismatch_count <= errors;
    pending_count  <= expected_index_q.size();
  end

endmodule

@@ dv/tb_top.sv @@
// testbench top for the nearest palette colour matcher: clock, reset, palette loads,
// match items, palette size changes and the final verdict
// depends on npcm_pkg, nearest_palette_color_matcher and npcm_match_checker
`timescale 1ns / 1ps

module tb_top;
  import npcm_pkg::*;

  localparam int         PALETTE_DEPTH = 256;
  localparam int         CYCLE_LIMIT   = 1_000_000;
  localparam int         DRAIN_CYCLES  = 16;
  localparam logic [1:0] OP_SPARE      = 2'd3;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               cfg_wr_en      = 1'b0;
  logic [SIZE_W-1:0]  cfg_wr_data    = '0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [1:0]         in_opcode      = OP_LOAD;
  logic [INDEX_W-1:0] in_entry_index = '0;
  logic [CHAN_W-1:0]  in_red         = '0;
  logic [CHAN_W-1:0]  in_green       = '0;
  logic [CHAN_W-1:0]  in_blue        = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [INDEX_W-1:0] out_color_index;
  int                 mismatch_count;
  int                 pending_count;

  // what the stimulus knows about the palette, used to aim queries and keep reads legal
  bit                 loaded  [PALETTE_DEPTH];
  logic [COLOR_W-1:0] colours [PALETTE_DEPTH];
  int                 active_size = 0;
  int                 gap_pct     = 0;
  int                 stall_pct   = 0;
  int                 stall_left  = 0;
  bit                 quiet       = 1'b0;

  always #2 clk = ~clk;

  nearest_palette_color_matcher #(
    .PALETTE_ENTRIES (PALETTE_DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_entry_index  (in_entry_index),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_color_index (out_color_index)
  );

  npcm_match_checker #(
    .PALETTE_ENTRIES (PALETTE_DEPTH)
  ) u_match_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_entry_index  (in_entry_index),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_color_index (out_color_index),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count)
  );

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // present one item and hold it until accepted, then maybe leave a gap
  task automatic send(input logic [1:0] op, input logic [INDEX_W-1:0] idx,
                      input logic [COLOR_W-1:0] colour);
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_entry_index <= idx;
    in_red         <= colour[2*CHAN_W +: CHAN_W];
    in_green       <= colour[CHAN_W +: CHAN_W];
    in_blue        <= colour[0 +: CHAN_W];
    do @(posedge clk); while (!in_ready);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [COLOR_W-1:0] colour);
    send(OP_LOAD, idx, colour);
    loaded[idx]  = 1'b1;
    colours[idx] = colour;
  endtask

  // a load may still be in flight when the last result has gone, hence the extra cycles
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] size);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    active_size = (size > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(size);
  endtask

  function automatic logic [COLOR_W-1:0] pick_colour();
    logic [COLOR_W-1:0] c;
    c = '0;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 9))
        0:       c[k*CHAN_W +: CHAN_W] = '0;
        1:       c[k*CHAN_W +: CHAN_W] = '1;
        default: c[k*CHAN_W +: CHAN_W] = CHAN_W'($urandom);
      endcase
    end
    return c;
  endfunction

  // half the time aimed at a searched entry: a direct hit or a near miss in the low bits
  function automatic logic [COLOR_W-1:0] query_colour();
    logic [COLOR_W-1:0] c;
    int                 pick;
    c = pick_colour();
    if (active_size > 0) begin
      pick = $urandom_range(0, active_size - 1);
      case ($urandom_range(0, 3))
        0:       c = colours[pick];
        1:       c = colours[pick] ^ COLOR_W'($urandom & 32'h0007_0707);
        default: ;
      endcase
    end
    return c;
  endfunction

  task automatic fill_palette();
    for (int i = 0; i < active_size; i++)
      if (!loaded[i])
        load_entry(INDEX_W'(i), pick_colour());
  endtask

  task automatic random_item();
    int                 roll;
    logic [INDEX_W-1:0] idx;
    logic [COLOR_W-1:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      if (active_size > 0 && $urandom_range(0, 3) != 0)
        idx = INDEX_W'($urandom_range(0, active_size - 1));
      else
        idx = INDEX_W'($urandom);
      // copying a searched colour sets up ties
      if (roll < 7 && active_size > 0)
        c = colours[$urandom_range(0, active_size - 1)];
      else
        c = pick_colour();
      load_entry(idx, c);
    end else if (roll < 24) begin
      send(OP_SPARE, INDEX_W'($urandom), COLOR_W'($urandom));
    end else begin
      send((roll < 62) ? OP_EXACT : OP_PIXEL, INDEX_W'($urandom), query_colour());
    end
  endtask

  task automatic run_phase(input int size, input int count);
    write_size(SIZE_W'(size));
    gap_pct   = 20 * $urandom_range(0, 2);
    stall_pct = 10 * $urandom_range(0, 3);
    fill_palette();
    repeat (count) random_item();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty palette answers index 0, spare opcode is dropped
    write_size(SIZE_W'(0));
    send(OP_EXACT, 8'hff, 24'hffffff);
    send(OP_PIXEL, 8'h00, 24'h000000);
    send(OP_SPARE, 8'ha5, 24'h5a5a5a);

    write_size(SIZE_W'(2));
    load_entry(8'd0, 24'h000000);
    load_entry(8'd1, 24'hffffff);
    send(OP_EXACT, 8'd0, 24'h000000);
    send(OP_EXACT, 8'd1, 24'hffffff);
    send(OP_EXACT, 8'd2, 24'h7f7f7f);
    send(OP_EXACT, 8'd3, 24'h808080);
    send(OP_PIXEL, 8'd4, 24'h000000);
    send(OP_PIXEL, 8'd5, 24'hffffff);
    send(OP_PIXEL, 8'd6, 24'h7f7f7f);
    send(OP_PIXEL, 8'd7, 24'h808080);
    // equal colours: lowest index wins
    load_entry(8'd1, 24'h000000);
    send(OP_EXACT, 8'd8, 24'h404040);
    // green weighs more than red
    load_entry(8'd0, 24'hff0000);
    load_entry(8'd1, 24'h00ff00);
    send(OP_EXACT, 8'd9, 24'h000000);
    send(OP_EXACT, 8'd10, 24'h7f7f00);
    load_entry(8'd255, 24'h123456);

    run_phase(16, 150);
    run_phase(2, 150);
    run_phase(256, 60);
    run_phase(1, 120);
    run_phase(511, 50);
    run_phase(0, 50);
    run_phase(40, 150);
    run_phase($urandom_range(3, 64), 150);
    quiet = 1'b1;
    run_phase(8, 120);

    wait_idle();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/npcm_pkg.sv
rtl/core/npcm_ram.sv
rtl/core/npcm_dist.sv
rtl/core/npcm_seq.sv
rtl/core/nearest_palette_color_matcher.sv
dv/npcm_match_checker.sv
dv/tb_top.sv
